FILE: hdl/emst_pkg.sv
package emst_pkg;

	// input coordinate port width and result length width
	localparam int COORD_PORT_W = 15;
	localparam int LEN_W        = 30;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

endpackage

FILE: hdl/emst_sqrt.sv
module emst_sqrt #(
	parameter int SW = 48,
	parameter int RW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [SW-1:0] radicand,
	output logic          done,
	output logic [RW-1:0] root
);
	localparam int CW = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            done_q;

	logic [RW+2:0] rem_nx;
	logic [RW+2:0] trial;
	logic          ge;

	// one result bit per cycle, restoring
	always_comb begin
		rem_nx = {rem_q, rad_q[2*RW-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_nx >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CW'(RW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= (2*RW)'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (RW+1)'(rem_nx - trial) : rem_nx[RW:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hdl/euclidean_mst_length_unit.sv
// channel | direction | handshake         | words
// points  | in        | start & !busy     | point_x, point_y, last_point
// result  | out       | done (one cycle)  | tree_length, points_dropped
//
// A point is taken whenever start is high and busy is low. The word with last_point
// set starts the tree build: n-1 sweeps over the distance memory through the
// multiply pipe, each followed by a bit-serial root of RW bits,
// with RW = COORD_BITS+1+FRAC_BITS.
// Reset clears the point count and control; memories need no clearing.
// done pulses for one cycle; the receiver cannot stall it.
module euclidean_mst_length_unit #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 15,
	parameter int FRAC_BITS  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [emst_pkg::COORD_PORT_W-1:0] point_x,
	input  logic [emst_pkg::COORD_PORT_W-1:0] point_y,
	input  logic                             last_point,
	output logic                             done,
	output logic [emst_pkg::LEN_W-1:0]       tree_length,
	output logic                             points_dropped
);
	import emst_pkg::*;

	localparam int IW  = $clog2(MAX_POINTS);
	localparam int CNW = $clog2(MAX_POINTS + 1);
	localparam int CB  = COORD_BITS;
	localparam int DW  = CB + 1;
	localparam int SQW = 2*CB + 1;
	localparam int WW  = SQW + 1;
	localparam int SW  = WW + 2*FRAC_BITS;
	localparam int RW  = (SW + 1) / 2;
	localparam int SUMW = ((RW > LEN_W) ? RW : LEN_W) + 1;

	typedef enum logic [2:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_ROOT, ST_WAIT} state_t;

	logic signed [CB-1:0] xmem [MAX_POINTS];
	logic signed [CB-1:0] ymem [MAX_POINTS];
	logic [WW-1:0]        dmem [MAX_POINTS];

	state_t state_q;
	logic [CNW-1:0] cnt_q, n_q, left_q;
	logic           ovf_q, first_q, done_q, drop_q;
	logic [LEN_W-1:0] len_q;
	logic [MAX_POINTS-1:0] intree_q;
	logic [IW-1:0]  j_q;
	logic signed [CB-1:0] cx_q, cy_q;

	logic                 min_v_q;
	logic [WW-1:0]        min_w_q;
	logic [IW-1:0]        min_i_q;
	logic signed [CB-1:0] min_x_q, min_y_q;

	// sweep pipe
	logic                 v_s1, v_s2, v_s3;
	logic [IW-1:0]        i_s1, i_s2, i_s3;
	logic signed [CB-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic [WW-1:0]        d_s1, d_s2, d_s3;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic [SQW-1:0]       sx_s3, sy_s3;

	logic signed [2*DW-1:0] pxx, pyy;
	logic [WW-1:0]          w_s3, nw_s3;
	logic                   take;
	logic                   full, issue, pipe_empty;
	logic [CNW-1:0]         n_eff;
	logic                   sq_done;
	logic [RW-1:0]          sq_root;
	logic [SW-1:0]          radicand;
	logic [SUMW-1:0]        sum;

	assign take  = start && (state_q == ST_IDLE);
	assign full  = cnt_q == CNW'(MAX_POINTS);
	assign n_eff = full ? cnt_q : cnt_q + 1'b1;
	assign issue = state_q == ST_SWEEP;
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;

	always_ff @(posedge clk) begin
		if (take && !full) begin
			xmem[cnt_q[IW-1:0]] <= point_x[CB-1:0];
			ymem[cnt_q[IW-1:0]] <= point_y[CB-1:0];
		end
		if (take && cnt_q == '0) begin
			cx_q <= point_x[CB-1:0];
			cy_q <= point_y[CB-1:0];
		end else if (state_q == ST_ROOT) begin
			cx_q <= min_x_q;
			cy_q <= min_y_q;
		end
		x_s1 <= xmem[j_q];
		y_s1 <= ymem[j_q];
		d_s1 <= dmem[j_q];
		if (v_s3) dmem[i_s3] <= nw_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		i_s1  <= j_q;
		i_s2  <= i_s1;
		i_s3  <= i_s2;
		x_s2  <= x_s1;
		y_s2  <= y_s1;
		x_s3  <= x_s2;
		y_s3  <= y_s2;
		d_s2  <= d_s1;
		d_s3  <= d_s2;
		dx_s2 <= DW'(x_s1) - DW'(cx_q);
		dy_s2 <= DW'(y_s1) - DW'(cy_q);
		sx_s3 <= pxx[SQW-1:0];
		sy_s3 <= pyy[SQW-1:0];
	end

	always_comb begin
		pxx   = dx_s2 * dx_s2;
		pyy   = dy_s2 * dy_s2;
		w_s3  = WW'(sx_s3) + WW'(sy_s3);
		nw_s3 = (first_q || w_s3 < d_s3) ? w_s3 : d_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_v_q <= 1'b0;
		end else if (state_q == ST_ROOT) begin
			min_v_q <= 1'b0;
		end else if (v_s3 && !intree_q[i_s3] && (!min_v_q || nw_s3 < min_w_q)) begin
			min_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && !intree_q[i_s3] && (!min_v_q || nw_s3 < min_w_q)) begin
			min_w_q <= nw_s3;
			min_i_q <= i_s3;
			min_x_q <= x_s3;
			min_y_q <= y_s3;
		end
	end

	assign radicand = SW'(min_w_q) << (2*FRAC_BITS);
	assign sum      = SUMW'(len_q) + SUMW'(sq_root);

	emst_sqrt #(.SW(SW), .RW(RW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (state_q == ST_ROOT),
		.radicand (radicand),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			n_q      <= '0;
			left_q   <= '0;
			ovf_q    <= 1'b0;
			first_q  <= 1'b0;
			done_q   <= 1'b0;
			drop_q   <= 1'b0;
			len_q    <= '0;
			intree_q <= '0;
			j_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (last_point) begin
							cnt_q  <= '0;
							ovf_q  <= 1'b0;
							drop_q <= ovf_q | full;
							len_q  <= '0;
							if (n_eff <= CNW'(1)) begin
								done_q <= 1'b1;
							end else begin
								n_q      <= n_eff;
								left_q   <= n_eff - 1'b1;
								first_q  <= 1'b1;
								intree_q <= MAX_POINTS'(1);
								j_q      <= '0;
								state_q  <= ST_SWEEP;
							end
						end else if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					if (CNW'(j_q) == n_q - 1'b1) begin
						j_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					intree_q[min_i_q] <= 1'b1;
					first_q <= 1'b0;
					left_q  <= left_q - 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (sq_done) begin
						if (sum > SUMW'(LEN_MAX)) len_q <= LEN_MAX;
						else                      len_q <= sum[LEN_W-1:0];
						if (left_q == '0) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SWEEP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign tree_length    = len_q;
	assign points_dropped = drop_q;

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a computation");

	a_root_has_min: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT |-> min_v_q)
		else $error("sweep ended with no candidate");

	a_pipe_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("distance write outside a sweep");

endmodule

FILE: tb/sv/euclidean_mst_length_unit_tb.sv
`timescale 1ns / 1ps

module euclidean_mst_length_unit_tb;
	import emst_pkg::*;

	localparam int MAX_PTS   = 64;
	localparam int FRAC      = 8;
	localparam int STALL_MAX = 100000;

	typedef struct packed {
		logic [LEN_W-1:0] tree_length;
		logic             points_dropped;
	} tree_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [COORD_PORT_W-1:0] point_x = '0;
	logic [COORD_PORT_W-1:0] point_y = '0;
	logic                    last_point = 1'b0;
	logic                    done;
	logic [LEN_W-1:0]        tree_length;
	logic                    points_dropped;

	// shadow of the point memory
	int                      set_x [MAX_PTS];
	int                      set_y [MAX_PTS];
	int                      set_count;
	bit                      set_overflow;
	tree_word_t              pending_trees [$];
	int                      errors = 0;
	int                      gap_pct;
	int                      words_sent;
	int                      quiet_cycles = 0;

	euclidean_mst_length_unit #(
		.MAX_POINTS(MAX_PTS),
		.COORD_BITS(COORD_PORT_W),
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point_x(point_x),
		.point_y(point_y),
		.last_point(last_point),
		.done(done),
		.tree_length(tree_length),
		.points_dropped(points_dropped)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned cand;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (cand * cand <= v)
				root = cand;
		end
		return root;
	endfunction

	// Prim over the stored points; the multiset of tree weights is unique,
	// so the truncated per-edge sum matches any Kruskal ordering
	function automatic longint unsigned spanning_length(input int n);
		longint unsigned best_w [MAX_PTS];
		bit              joined [MAX_PTS];
		longint unsigned total;
		longint signed   dx, dy;
		longint unsigned w;
		int              pick;
		total = 0;
		for (int i = 0; i < n; i++) begin
			joined[i] = 1'b0;
			best_w[i] = '1;
		end
		if (n < 2)
			return 64'd0;
		best_w[0] = 0;
		for (int k = 0; k < n; k++) begin
			pick = -1;
			for (int i = 0; i < n; i++)
				if (!joined[i] && (pick < 0 || best_w[i] < best_w[pick]))
					pick = i;
			joined[pick] = 1'b1;
			if (k > 0)
				total += int_sqrt(best_w[pick] << (2 * FRAC));
			for (int i = 0; i < n; i++) begin
				if (!joined[i]) begin
					dx = set_x[i] - set_x[pick];
					dy = set_y[i] - set_y[pick];
					w = dx * dx + dy * dy;
					if (w < best_w[i])
						best_w[i] = w;
				end
			end
		end
		if (total > LEN_MAX)
			total = 64'(LEN_MAX);
		return total;
	endfunction

	function automatic void take_point(input logic [COORD_PORT_W-1:0] px,
			input logic [COORD_PORT_W-1:0] py, input bit lst);
		tree_word_t exp_word;
		if (set_count < MAX_PTS) begin
			set_x[set_count] = int'($signed(px));
			set_y[set_count] = int'($signed(py));
			set_count++;
		end else begin
			set_overflow = 1'b1;
		end
		if (lst) begin
			exp_word.tree_length = LEN_W'(spanning_length(set_count));
			exp_word.points_dropped = set_overflow;
			pending_trees = {pending_trees, exp_word};
			set_count = 0;
			set_overflow = 1'b0;
		end
	endfunction

	// start stays high between back-to-back words; lowered only for gaps
	task automatic send_point(input logic [COORD_PORT_W-1:0] px,
			input logic [COORD_PORT_W-1:0] py, input bit lst);
		int gap;
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		point_x <= px;
		point_y <= py;
		last_point <= lst;
		do
			@(posedge clk);
		while (busy);
		take_point(px, py, lst);
		words_sent++;
	endtask

	task automatic drain_trees();
		start <= 1'b0;
		@(posedge clk);
		while (pending_trees.size() > 0)
			@(posedge clk);
	endtask

	task automatic test_small_sets();
		// lone point
		send_point(15'd0, 15'd0, 1'b1);
		// opposite corners
		send_point(15'h4000, 15'h4000, 1'b0);
		send_point(15'h3FFF, 15'h3FFF, 1'b1);
		send_point(15'h3FFF, 15'h4000, 1'b0);
		send_point(15'h4000, 15'h3FFF, 1'b0);
		send_point(15'd0, 15'd0, 1'b1);
		// coincident points, zero weights
		repeat (2) send_point(15'd5, 15'd5, 1'b0);
		send_point(15'd5, 15'd5, 1'b1);
		// square: ties everywhere
		send_point(15'd0, 15'd0, 1'b0);
		send_point(15'd10, 15'd0, 1'b0);
		send_point(15'd0, 15'd10, 1'b0);
		send_point(15'd10, 15'd10, 1'b1);
		send_point(-15'sd1, 15'd1, 1'b0);
		send_point(15'd1, -15'sd1, 1'b1);
	endtask

	task automatic test_overflow();
		// exactly full, nothing dropped
		for (int i = 0; i < MAX_PTS; i++)
			send_point(COORD_PORT_W'($urandom), COORD_PORT_W'($urandom),
				i == MAX_PTS - 1);
		// extras dropped, last word among the dropped ones
		for (int i = 0; i < MAX_PTS + 3; i++)
			send_point(COORD_PORT_W'($urandom), COORD_PORT_W'($urandom),
				i == MAX_PTS + 2);
	endtask

	task automatic test_random_sets(input int pct, input int count);
		int n;
		int r;
		bit narrow;
		gap_pct = pct;
		count += words_sent;
		while (words_sent < count) begin
			r = $urandom_range(99);
			if (r < 4)
				n = 1;
			else if (r < 6)
				n = $urandom_range(60, 68);
			else
				n = $urandom_range(2, 12);
			narrow = $urandom_range(2) == 0;
			for (int i = 0; i < n; i++) begin
				if (narrow)
					send_point(COORD_PORT_W'($urandom_range(16) - 8),
						COORD_PORT_W'($urandom_range(16) - 8), i == n - 1);
				else
					send_point(COORD_PORT_W'($urandom), COORD_PORT_W'($urandom),
						i == n - 1);
			end
		end
	endtask

	task automatic test_hold_off();
		send_point(COORD_PORT_W'($urandom), COORD_PORT_W'($urandom), 1'b0);
		send_point(COORD_PORT_W'($urandom), COORD_PORT_W'($urandom), 1'b1);
		drain_trees();
		send_point(COORD_PORT_W'($urandom), COORD_PORT_W'($urandom), 1'b0);
		send_point(COORD_PORT_W'($urandom), COORD_PORT_W'($urandom), 1'b1);
	endtask

	always @(posedge clk) begin
		tree_word_t exp_word;
		if (arst_n && done) begin
			if (pending_trees.size() == 0) begin
				$display("%0t: unexpected word len=%0d dropped=%0d", $time,
					tree_length, points_dropped);
				errors++;
			end else begin
				exp_word = pending_trees.pop_front();
				if (tree_length !== exp_word.tree_length) begin
					$display("%0t: tree_length expected %0d actual %0d", $time,
						exp_word.tree_length, tree_length);
					errors++;
				end
				if (points_dropped !== exp_word.points_dropped) begin
					$display("%0t: points_dropped expected %0d actual %0d", $time,
						exp_word.points_dropped, points_dropped);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no word moving either way
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		set_count = 0;
		set_overflow = 1'b0;
		gap_pct = 0;
		words_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_sets();
		test_overflow();
		test_random_sets(15, 500);
		test_hold_off();
		test_random_sets(76, 500);
		test_random_sets(0, 500);
		drain_trees();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
